/* hw/rtl/ceb_pkg.sv */
// shared types and constants of the coincidence event builder
package ceb_pkg;

    localparam int NCH      = 15;
    localparam int TIME_W   = 48;
    localparam int ENERGY_W = 16;
    localparam int WORD_W   = 16;
    localparam int SUM_W    = 52;

    localparam logic [WORD_W-1:0] HDR_BASE     = 16'hF002;
    localparam logic [WORD_W-1:0] WORDS_PER_CH = 16'd5;
    localparam logic [15:0]       WINDOW_RST   = 16'd80;
    localparam logic [15:0]       OFFSET_RST   = 16'd2000;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    typedef struct packed {
        logic                build;
        logic [3:0]          qi;
        logic [TIME_W-1:0]   hit_time;
        logic [ENERGY_W-1:0] hit_energy;
    } t_op;

    typedef struct packed {
        logic [15:0] window;
        logic [15:0] offset;
    } t_cfg;

endpackage

/* hw/rtl/ceb_front.sv */
// front end: accepts words, drops pushes to channel zero, two-entry op queue
module ceb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [3:0]                    i_channel,
    input  logic [ceb_pkg::TIME_W-1:0]    i_hit_time,
    input  logic [ceb_pkg::ENERGY_W-1:0]  i_hit_energy,
    output logic                          o_op_valid,
    output ceb_pkg::t_op                  o_op,
    input  logic                          i_op_take
);

    ceb_pkg::t_op r_q [2];
    logic [1:0]   r_cnt;
    logic         r_wp;
    logic         r_rp;
    logic         w_keep;
    logic         w_take;

    assign o_in_ready = (r_cnt != 2'd2);
    assign w_keep     = i_in_valid && o_in_ready && (i_command || (i_channel != 4'd0));
    assign o_op_valid = (r_cnt != 2'd0);
    assign o_op       = r_q[r_rp];
    assign w_take     = o_op_valid && i_op_take;

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_q[r_wp] <= '{build: i_command, qi: i_channel - 4'd1,
                           hit_time: i_hit_time, hit_energy: i_hit_energy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_keep) r_wp <= ~r_wp;
            if (w_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_keep} - {1'b0, w_take};
        end
    end

endmodule

/* hw/rtl/ceb_div.sv */
// radix-2 restoring divider, sum of taken times by taken count
module ceb_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ceb_pkg::SUM_W-1:0]   i_dividend,
    input  logic [3:0]                  i_divisor,
    output logic                        o_done,
    output logic [ceb_pkg::SUM_W-1:0]   o_quot
);

    logic                      r_busy;
    logic                      r_done;
    logic [5:0]                r_cnt;
    logic [ceb_pkg::SUM_W-1:0] r_q;
    logic [3:0]                r_rem;
    logic [3:0]                r_dvs;
    logic [4:0]                w_sh;
    logic                      w_ge;

    assign w_sh   = {r_rem, r_q[ceb_pkg::SUM_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= 4'd0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? 4'(w_sh - {1'b0, r_dvs}) : w_sh[3:0];
                r_q   <= {r_q[ceb_pkg::SUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(ceb_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/ceb_back.sv */
// back end: hit memory, queue pointers, build sequencer and word output register
module ceb_back #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_op_valid,
    input  ceb_pkg::t_op                  i_op,
    output logic                          o_op_take,
    input  ceb_pkg::t_cfg                 i_cfg,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ceb_pkg::WORD_W-1:0]    o_word,
    output logic                          o_word_valid,
    output logic [3:0]                    o_taken_count,
    output logic                          o_last
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = ceb_pkg::NCH * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int NCH       = ceb_pkg::NCH;
    localparam int TW        = ceb_pkg::TIME_W;
    localparam int EW        = ceb_pkg::ENERGY_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_SEL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state             r_state;
    logic [TW+EW-1:0]   r_mem [MEM_DEPTH];
    logic [TW+EW-1:0]   r_rd;
    logic [PTR_W-1:0]   r_hd [NCH];
    logic [PTR_W-1:0]   r_tl [NCH];
    logic [CNT_W-1:0]   r_fill [NCH];
    logic [TW-1:0]      r_t [NCH];
    logic [EW-1:0]      r_e [NCH];
    logic [NCH-1:0]     r_hv;
    logic [NCH-1:0]     r_tk;
    logic [TW-1:0]      r_earliest;
    logic               r_any;
    logic [3:0]         r_cnt;
    logic               r_pend;
    logic [3:0]         r_pend_q;
    logic [ceb_pkg::SUM_W-1:0] r_sum;
    logic [3:0]         r_popped;
    logic [3:0]         r_n;
    logic [15:0]        r_ref;
    logic               r_empty;
    logic               r_body;
    logic [2:0]         r_sub;
    logic [3:0]         r_ch;
    logic               r_out_valid;
    logic [15:0]        r_word;
    logic               r_word_valid;
    logic [3:0]         r_taken;
    logic               r_last;

    logic               w_push;
    logic               w_full;
    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [3:0]         w_scan_q;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [TW:0]        w_lim;
    logic               w_sel_take;
    logic [ceb_pkg::SUM_W-1:0] w_sum_next;
    logic [3:0]         w_pop_next;
    logic [3:0]         w_n_next;
    logic               w_div_start;
    logic               w_div_done;
    logic [ceb_pkg::SUM_W-1:0] w_quot;
    logic               w_can_emit;
    logic               w_emit;
    logic [3:0]         w_qi;
    logic [3:0]         w_pq;
    logic               w_pt;
    logic [3:0]         w_rsel;
    logic [15:0]        w_te;
    logic [15:0]        w_tt;
    logic               w_more;
    logic [NCH-1:0]     w_above;
    logic [15:0]        w_body_word;
    logic [15:0]        w_hdr_word;

    // push path
    assign w_push    = (r_state == ST_IDLE) && i_op_valid && !i_op.build;
    assign w_full    = (r_fill[i_op.qi] == CNT_W'(QUEUE_DEPTH));
    assign w_wr_en   = w_push && !w_full;
    assign w_wr_addr = ADDR_W'(i_op.qi) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_tl[i_op.qi]);
    assign o_op_take = (r_state == ST_IDLE) && i_op_valid;

    // head read during the scan
    assign w_scan_q  = (r_cnt == 4'(NCH)) ? 4'd0 : r_cnt;
    assign w_rd_addr = ADDR_W'(w_scan_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_hd[w_scan_q]);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= {i_op.hit_time, i_op.hit_energy};
        r_rd <= r_mem[w_rd_addr];
    end

    // selection of one head per cycle
    assign w_lim       = {1'b0, r_earliest} + (TW+1)'(i_cfg.window);
    assign w_sel_take  = r_hv[r_cnt] && ({1'b0, r_t[r_cnt]} < w_lim);
    assign w_sum_next  = w_sel_take ? r_sum + ceb_pkg::SUM_W'(r_t[r_cnt]) : r_sum;
    assign w_pop_next  = r_popped + {3'b0, w_sel_take};
    assign w_n_next    = r_n + {3'b0, w_sel_take && (r_cnt >= 4'd3)};
    assign w_div_start = (r_state == ST_SEL) && (r_cnt == 4'(NCH - 1)) && (w_n_next != 4'd0);

    ceb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum_next),
        .i_divisor  (w_pop_next),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // record words
    assign w_can_emit = !r_out_valid || i_out_ready;
    assign w_qi       = r_ch - 4'd1;
    assign w_pq       = {2'b0, r_ch[3:2]} - 4'd1;
    assign w_pt       = r_tk[w_pq];
    assign w_rsel     = (r_sub < 3'd3) ? w_qi : w_pq;
    assign w_te       = r_e[w_rsel];
    assign w_tt       = r_t[w_rsel][15:0] - r_ref;
    assign w_above    = r_tk >> r_ch;
    assign w_more     = |w_above;
    // a word enters the output register this cycle
    assign w_emit     = (r_state == ST_EMIT) && w_can_emit && (r_empty || !r_body || r_tk[w_qi]);

    always_comb begin
        unique case (r_sub)
            3'd0:    w_body_word = {12'b0, r_ch - 4'd4};
            3'd1:    w_body_word = w_te;
            3'd2:    w_body_word = w_tt;
            3'd3:    w_body_word = w_pt ? w_te : 16'd0;
            3'd4:    w_body_word = w_pt ? w_tt : 16'd0;
            default: w_body_word = 16'd0;
        endcase
    end

    always_comb begin
        unique case (r_sub)
            3'd0:    w_hdr_word = ceb_pkg::HDR_BASE + 16'(r_n) * ceb_pkg::WORDS_PER_CH;
            3'd2:    w_hdr_word = {12'b0, r_n};
            default: w_hdr_word = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= 4'd0;
            for (int i = 0; i < NCH; i++) begin
                r_hd[i]   <= '0;
                r_tl[i]   <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready && !w_emit) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_op_valid && i_op.build) begin
                        r_state  <= ST_SCAN;
                        r_cnt    <= 4'd0;
                        r_pend   <= 1'b0;
                        r_any    <= 1'b0;
                        r_hv     <= '0;
                        r_tk     <= '0;
                        r_sum    <= '0;
                        r_popped <= 4'd0;
                        r_n      <= 4'd0;
                    end else if (w_wr_en) begin
                        r_tl[i_op.qi]   <= (r_tl[i_op.qi] == PTR_W'(QUEUE_DEPTH - 1))
                                           ? '0 : r_tl[i_op.qi] + PTR_W'(1);
                        r_fill[i_op.qi] <= r_fill[i_op.qi] + CNT_W'(1);
                    end
                end
                ST_SCAN: begin
                    if (r_cnt != 4'(NCH)) begin
                        r_pend         <= 1'b1;
                        r_pend_q       <= r_cnt;
                        r_hv[r_cnt]    <= (r_fill[r_cnt] != '0);
                        r_cnt          <= r_cnt + 4'd1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && r_hv[r_pend_q]) begin
                        r_t[r_pend_q] <= r_rd[TW+EW-1:EW];
                        r_e[r_pend_q] <= r_rd[EW-1:0];
                        if (!r_any || (r_rd[TW+EW-1:EW] < r_earliest)) begin
                            r_earliest <= r_rd[TW+EW-1:EW];
                        end
                        r_any <= 1'b1;
                    end
                    if ((r_cnt == 4'(NCH)) && !r_pend) begin
                        r_state <= ST_SEL;
                        r_cnt   <= 4'd0;
                    end
                end
                ST_SEL: begin
                    r_sum    <= w_sum_next;
                    r_popped <= w_pop_next;
                    r_n      <= w_n_next;
                    if (w_sel_take) begin
                        r_tk[r_cnt]   <= 1'b1;
                        r_hd[r_cnt]   <= (r_hd[r_cnt] == PTR_W'(QUEUE_DEPTH - 1))
                                         ? '0 : r_hd[r_cnt] + PTR_W'(1);
                        r_fill[r_cnt] <= r_fill[r_cnt] - CNT_W'(1);
                    end
                    if (r_cnt == 4'(NCH - 1)) begin
                        r_empty <= (w_n_next == 4'd0);
                        r_body  <= 1'b0;
                        r_sub   <= 3'd0;
                        r_ch    <= 4'd4;
                        r_state <= (w_n_next == 4'd0) ? ST_EMIT : ST_DIV;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_ref   <= w_quot[15:0] - i_cfg.offset;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (r_empty) begin
                        if (w_can_emit) begin
                            r_out_valid  <= 1'b1;
                            r_word       <= 16'd0;
                            r_word_valid <= 1'b0;
                            r_taken      <= r_popped;
                            r_last       <= 1'b1;
                            r_state      <= ST_IDLE;
                        end
                    end else if (!r_body) begin
                        if (w_can_emit) begin
                            r_out_valid  <= 1'b1;
                            r_word       <= w_hdr_word;
                            r_word_valid <= 1'b1;
                            r_taken      <= r_popped;
                            r_last       <= 1'b0;
                            if (r_sub == 3'd2) begin
                                r_body <= 1'b1;
                                r_sub  <= 3'd0;
                            end else begin
                                r_sub <= r_sub + 3'd1;
                            end
                        end
                    end else if (!r_tk[w_qi]) begin
                        r_ch <= r_ch + 4'd1;
                    end else if (w_can_emit) begin
                        r_out_valid  <= 1'b1;
                        r_word       <= w_body_word;
                        r_word_valid <= 1'b1;
                        r_taken      <= r_popped;
                        r_last       <= (r_sub == 3'd4) && !w_more;
                        if (r_sub == 3'd4) begin
                            r_sub <= 3'd0;
                            r_ch  <= r_ch + 4'd1;
                            if (!w_more) r_state <= ST_IDLE;
                        end else begin
                            r_sub <= r_sub + 3'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word        = r_word;
    assign o_word_valid  = r_word_valid;
    assign o_taken_count = r_taken;
    assign o_last        = r_last;

endmodule

/* hw/rtl/coincidence_event_builder_core.sv */
// top level of the coincidence event builder: config registers, front end, back end
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_command i_channel i_hit_time i_hit_energy
// out       output     o_out_valid / i_out_ready o_word o_word_valid o_taken_count o_last
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// a push word is taken by the back end only while it is idle; the front queue holds two words
// a build leaves the queue, then come the head reads (one memory read port) and the
// selection, then the bit-serial divider when any channel 4..15 is taken, then the
// record words, with each untaken channel skipped
// reset is synchronous active low; queues come up empty, hit memory is not cleared
// the output register stalls the build sequencer; the front keeps taking words
// until its two-entry queue fills
module coincidence_event_builder_core #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [3:0]                    i_channel,
    input  logic [ceb_pkg::TIME_W-1:0]    i_hit_time,
    input  logic [ceb_pkg::ENERGY_W-1:0]  i_hit_energy,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ceb_pkg::WORD_W-1:0]    o_word,
    output logic                          o_word_valid,
    output logic [3:0]                    o_taken_count,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    ceb_pkg::t_cfg r_cfg;
    ceb_pkg::t_op  w_op;
    logic          w_op_valid;
    logic          w_op_take;

    // config writes are always accepted and land in the config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window <= ceb_pkg::WINDOW_RST;
            r_cfg.offset <= ceb_pkg::OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ceb_pkg::CFG_WINDOW: r_cfg.window <= i_cfg_data;
                ceb_pkg::CFG_OFFSET: r_cfg.offset <= i_cfg_data;
                default:             r_cfg        <= r_cfg;
            endcase
        end
    end

    // front: accept and classify input words
    ceb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_channel    (i_channel),
        .i_hit_time   (i_hit_time),
        .i_hit_energy (i_hit_energy),
        .o_op_valid   (w_op_valid),
        .o_op         (w_op),
        .i_op_take    (w_op_take)
    );

    // back: queues, event building and record output
    ceb_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (w_op_valid),
        .i_op          (w_op),
        .o_op_take     (w_op_take),
        .i_cfg         (r_cfg),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_word        (o_word),
        .o_word_valid  (o_word_valid),
        .o_taken_count (o_taken_count),
        .o_last        (o_last)
    );

    // an empty build is always a single closing word
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_word_valid |-> o_last)
        else $error("empty build word without last");

    // a record word implies at least one popped head
    a_rec_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_valid |-> o_taken_count != 4'd0)
        else $error("record word with zero taken count");

    // a record closes only with real data
    a_last_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && o_word_valid |-> o_taken_count != 4'd0)
        else $error("record closed without taken heads");

endmodule
